// ----- hdl/point_feature_interaction_matrix_defines.svh -----
// Assertion macros shared by the point feature interaction matrix design.
`ifndef POINT_FEATURE_INTERACTION_MATRIX_DEFINES_SVH
`define POINT_FEATURE_INTERACTION_MATRIX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFIM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pfim_pkg.sv -----
// Shared types and constants of the point feature interaction matrix.
package pfim_pkg;

  // Default number of fraction bits of the result entries.
  localparam int unsigned OUT_FRAC_BITS_DEF = 16;

  // Quotient width of each division and number of divider stages.
  localparam int unsigned QUOT_W     = 32;
  localparam int unsigned DIV_STAGES = QUOT_W + 1;

  // A raw denominator is at most focal times depth: 16 + 23 bits.
  localparam int unsigned RAW_DEN_W = 39;
  localparam int unsigned DEN_W     = RAW_DEN_W + 1;

  // Numerator magnitude and rounded numerator widths above the fraction bits.
  localparam int unsigned MAG_EXTRA = 33;
  localparam int unsigned NUM_EXTRA = 35;

  // Parallel division lanes per row.
  localparam int unsigned NUM_LANES = 5;

  // Reset value of both focal lengths: 1.0 in Q12.4.
  localparam logic [15:0] FOCAL_RESET = 16'd16;

  typedef enum logic [1:0] {
    CFG_FOCAL_X  = 2'd0,
    CFG_FOCAL_Y  = 2'd1,
    CFG_CENTER_X = 2'd2,
    CFG_CENTER_Y = 2'd3
  } cfg_idx_e;

  // Result of one division lane.
  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic              ovf;
    logic              neg;
  } div_res_t;

  // Per-row control that travels alongside the data.
  typedef struct packed {
    logic last;
    logic dinv;
    logic finv;
  } row_ctrl_t;

endpackage

// ----- hdl/point_feature_interaction_matrix.sv -----
// Each row passes stages 1 to 4, the divider stages and the output register.
// Throughput: one row per cycle on the output while out_ready_i is high; the two rows
// of a feature, u then v, share one 38-stage pipeline; a new feature enters as v issues.
// The whole pipeline holds while a shown row is not taken; the feature buffer
// still takes one transaction. Reset clears valids and sets default intrinsics.
module point_feature_interaction_matrix #(
  parameter int unsigned OUT_FRAC_BITS = pfim_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        pixel_u_i,
  input  logic [15:0]        pixel_v_i,
  input  logic signed [23:0] depth_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               last_row_o,
  output logic signed [31:0] entry_vx_o,
  output logic signed [31:0] entry_vy_o,
  output logic signed [31:0] entry_vz_o,
  output logic signed [31:0] entry_wx_o,
  output logic signed [31:0] entry_wy_o,
  output logic signed [31:0] entry_wz_o,
  output logic               depth_invalid_o,
  output logic               focal_invalid_o
);
  import pfim_pkg::*;

  `include "point_feature_interaction_matrix_defines.svh"

  localparam int unsigned MAG_W    = OUT_FRAC_BITS + MAG_EXTRA;
  localparam int unsigned NUM_W    = OUT_FRAC_BITS + NUM_EXTRA;
  localparam int unsigned SHIFT_Z  = 16 + OUT_FRAC_BITS;
  localparam int unsigned PIPE_LEN = 4 + DIV_STAGES;

  // Saturate an unsigned quotient with its sign into a 32 bit entry.
  function automatic logic [31:0] sat_entry(div_res_t r);
    logic [31:0] qn;
    qn = -r.quot;
    if (r.ovf || r.quot[31]) begin
      return r.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r.neg ? qn : r.quot;
  endfunction

  // Configuration registers.
  logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FOCAL_RESET;
      focal_y_q  <= FOCAL_RESET;
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FOCAL_X:  focal_x_q  <= cfg_wdata_i;
        CFG_FOCAL_Y:  focal_y_q  <= cfg_wdata_i;
        CFG_CENTER_X: center_x_q <= cfg_wdata_i;
        CFG_CENTER_Y: center_y_q <= cfg_wdata_i;
      endcase
    end
  end

  // Global pipeline advance: the output register is free or being emptied.
  logic adv;
  assign adv = !out_valid_o || out_ready_i;

  // Feature buffer: holds one transaction and issues the u row, then the v row.
  logic               f_valid_q, f_phase_q;
  logic [15:0]        f_u_q, f_v_q;
  logic signed [23:0] f_d_q;
  logic               in_acc;

  assign in_ready_o = !f_valid_q || (f_phase_q && adv);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      f_phase_q <= 1'b0;
    end else if (in_acc) begin
      f_valid_q <= 1'b1;
      f_phase_q <= 1'b0;
    end else if (adv && f_valid_q) begin
      f_valid_q <= !f_phase_q;
      f_phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      f_u_q <= pixel_u_i;
      f_v_q <= pixel_v_i;
      f_d_q <= depth_i;
    end
  end

  // Row valids and control travel down the pipeline together.
  logic [PIPE_LEN-1:0] pipe_v_q;
  row_ctrl_t           ctrl_q [PIPE_LEN];
  logic                out_valid_q;
  row_ctrl_t           row_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_v_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      pipe_v_q    <= {pipe_v_q[PIPE_LEN-2:0], f_valid_q};
      out_valid_q <= pipe_v_q[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctrl_q[0] <= row_new;
      for (int k = 1; k < PIPE_LEN; k++) begin
        ctrl_q[k] <= ctrl_q[k-1];
      end
    end
  end

  // Stage 1: centre the coordinates and pick own and other axis for the row.
  logic signed [16:0] da, db, own, oth;
  logic [16:0]        own_n, oth_n;
  logic [15:0]        s1_pm_q, s1_qm_q, s1_fo_q, s1_fq_q;
  logic               s1_pneg_q, s1_qneg_q;
  logic [22:0]        s1_d_q;

  assign da    = $signed({1'b0, f_u_q}) - $signed({1'b0, center_x_q});
  assign db    = $signed({1'b0, f_v_q}) - $signed({1'b0, center_y_q});
  assign own   = f_phase_q ? db : da;
  assign oth   = f_phase_q ? da : db;
  assign own_n = -own;
  assign oth_n = -oth;

  assign row_new.last = f_phase_q;
  assign row_new.dinv = (f_d_q == '0) || f_d_q[23];
  assign row_new.finv = (focal_x_q == '0) || (focal_y_q == '0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pm_q   <= own[16] ? own_n[15:0] : own[15:0];
      s1_qm_q   <= oth[16] ? oth_n[15:0] : oth[15:0];
      s1_pneg_q <= own[16];
      s1_qneg_q <= oth[16];
      s1_fo_q   <= f_phase_q ? focal_y_q : focal_x_q;
      s1_fq_q   <= f_phase_q ? focal_x_q : focal_y_q;
      s1_d_q    <= f_d_q[22:0];
    end
  end

  // Stage 2: the products of focal lengths, depth and coordinates.
  logic [RAW_DEN_W-1:0] s2_fod_q;
  logic [31:0]          s2_fofq_q, s2_fofo_q, s2_pq_q, s2_pp_q;
  logic [15:0]          s2_pm_q, s2_qm_q, s2_fq_q;
  logic                 s2_pneg_q, s2_qneg_q;
  logic [22:0]          s2_d_q;
  logic [RAW_DEN_W-1:0] fod;

  assign fod = RAW_DEN_W'(s1_fo_q) * RAW_DEN_W'(s1_d_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_fod_q  <= fod;
      s2_fofq_q <= 32'(s1_fo_q) * 32'(s1_fq_q);
      s2_fofo_q <= 32'(s1_fo_q) * 32'(s1_fo_q);
      s2_pq_q   <= 32'(s1_pm_q) * 32'(s1_qm_q);
      s2_pp_q   <= 32'(s1_pm_q) * 32'(s1_pm_q);
      s2_pm_q   <= s1_pm_q;
      s2_qm_q   <= s1_qm_q;
      s2_fq_q   <= s1_fq_q;
      s2_pneg_q <= s1_pneg_q;
      s2_qneg_q <= s1_qneg_q;
      s2_d_q    <= s1_d_q;
    end
  end

  // Stage 3: numerator magnitude, denominator and sign of each lane.
  // Lanes: inverse depth, coordinate over depth, cross term, square term,
  // and the other coordinate.
  logic [MAG_W-1:0]     s3_mag_q [NUM_LANES];
  logic [RAW_DEN_W-1:0] s3_den_q [NUM_LANES];
  logic                 s3_neg_q [NUM_LANES];
  logic [32:0]          sq_sum;
  logic                 last2;

  assign sq_sum = {1'b0, s2_fofo_q} + {1'b0, s2_pp_q};
  assign last2  = ctrl_q[1].last;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_mag_q[0] <= MAG_W'(1) << SHIFT_Z;
      s3_den_q[0] <= RAW_DEN_W'(s2_d_q);
      s3_neg_q[0] <= 1'b1;
      s3_mag_q[1] <= MAG_W'(s2_pm_q) << SHIFT_Z;
      s3_den_q[1] <= s2_fod_q;
      s3_neg_q[1] <= s2_pneg_q;
      s3_mag_q[2] <= MAG_W'(s2_pq_q) << OUT_FRAC_BITS;
      s3_den_q[2] <= RAW_DEN_W'(s2_fofq_q);
      s3_neg_q[2] <= s2_pneg_q ^ s2_qneg_q ^ last2;
      s3_mag_q[3] <= MAG_W'(sq_sum) << OUT_FRAC_BITS;
      s3_den_q[3] <= RAW_DEN_W'(s2_fofo_q);
      s3_neg_q[3] <= !last2;
      s3_mag_q[4] <= MAG_W'(s2_qm_q) << OUT_FRAC_BITS;
      s3_den_q[4] <= RAW_DEN_W'(s2_fq_q);
      s3_neg_q[4] <= s2_qneg_q ^ last2;
    end
  end

  // Stage 4: rounding numerator 2*mag + den over divisor 2*den.
  logic [NUM_W-1:0] s4_num_q [NUM_LANES];
  logic [DEN_W-1:0] s4_den_q [NUM_LANES];
  logic             s4_neg_q [NUM_LANES];
  div_res_t         dres     [NUM_LANES];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        s4_num_q[l] <= NUM_W'({s3_mag_q[l], 1'b0}) + NUM_W'(s3_den_q[l]);
        s4_den_q[l] <= {s3_den_q[l], 1'b0};
        s4_neg_q[l] <= s3_neg_q[l];
      end
    end
  end

  // Division lanes.
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    pfim_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
    ) u_div (
      .clk_i (clk_i),
      .adv_i (adv),
      .num_i (s4_num_q[l]),
      .den_i (s4_den_q[l]),
      .neg_i (s4_neg_q[l]),
      .res_o (dres[l])
    );
  end

  // Output register: saturate, place entries by row and zero invalid rows.
  logic [31:0] ent [NUM_LANES];
  row_ctrl_t   ctrl_end;
  logic        zero_row;
  logic [31:0] vx_d, vy_d, vz_d, wx_d, wy_d, wz_d;

  assign ctrl_end = ctrl_q[PIPE_LEN-1];
  assign zero_row = ctrl_end.dinv || ctrl_end.finv;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      ent[l] = zero_row ? '0 : sat_entry(dres[l]);
    end
    vx_d = ctrl_end.last ? '0 : ent[0];
    vy_d = ctrl_end.last ? ent[0] : '0;
    vz_d = ent[1];
    wx_d = ctrl_end.last ? ent[3] : ent[2];
    wy_d = ctrl_end.last ? ent[2] : ent[3];
    wz_d = ent[4];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      last_row_o      <= ctrl_end.last;
      depth_invalid_o <= ctrl_end.dinv;
      focal_invalid_o <= ctrl_end.finv;
      entry_vx_o      <= vx_d;
      entry_vy_o      <= vy_d;
      entry_vz_o      <= vz_d;
      entry_wx_o      <= wx_d;
      entry_wy_o      <= wy_d;
      entry_wz_o      <= wz_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks on the row sequencing and the zeroed entries.
  `PFIM_ASSERT_NEXT(a_accept_loads_buffer, in_valid_i && in_ready_o,
                    f_valid_q && !f_phase_q, "accepted transaction did not start a u row")
  `PFIM_ASSERT_NEXT(a_v_row_follows_u_row, out_valid_o && out_ready_i && !last_row_o,
                    out_valid_o && last_row_o, "u row was not directly followed by its v row")
  `PFIM_ASSERT_NOW(a_invalid_row_zero, out_valid_o && (depth_invalid_o || focal_invalid_o),
                   entry_vx_o == '0 && entry_vy_o == '0 && entry_vz_o == '0 &&
                   entry_wx_o == '0 && entry_wy_o == '0 && entry_wz_o == '0,
                   "invalid row carries non-zero entries")
  `PFIM_ASSERT_NOW(a_structural_zero, out_valid_o,
                   last_row_o ? (entry_vx_o == '0) : (entry_vy_o == '0),
                   "structurally zero entry is non-zero")

endmodule

// ----- hdl/pfim_div.sv -----
// Pipelined restoring divider lane, one quotient bit per stage after the seed stage.
module pfim_div #(
  parameter int unsigned NUM_W = pfim_pkg::OUT_FRAC_BITS_DEF + pfim_pkg::NUM_EXTRA,
  parameter int unsigned DEN_W = pfim_pkg::DEN_W
) (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  input  logic               neg_i,
  output pfim_pkg::div_res_t res_o
);
  import pfim_pkg::*;

  localparam int unsigned HI_W = NUM_W - QUOT_W;

  logic [DEN_W-1:0]  rem_q [DIV_STAGES];
  logic [QUOT_W-1:0] nq_q  [DIV_STAGES];
  logic [DEN_W-1:0]  den_q [DIV_STAGES];
  logic              ovf_q [DIV_STAGES];
  logic              neg_q [DIV_STAGES];

  logic [HI_W-1:0]  hi;
  logic [DEN_W-1:0] hi_ext;

  // The upper numerator bits seed the remainder; if they already reach the
  // divisor, the quotient does not fit in the quotient width.
  assign hi     = num_i[NUM_W-1:QUOT_W];
  assign hi_ext = DEN_W'(hi);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0] <= hi_ext;
      nq_q[0]  <= num_i[QUOT_W-1:0];
      den_q[0] <= den_i;
      ovf_q[0] <= (hi_ext >= den_i);
      neg_q[0] <= neg_i;
    end
  end

  // Each stage brings down one numerator bit and shifts in one quotient bit.
  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;

    assign trial = {rem_q[s-1], nq_q[s-1][QUOT_W-1]};
    assign diff  = trial - {1'b0, den_q[s-1]};
    assign take  = (trial >= {1'b0, den_q[s-1]});

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_q[s]  <= {nq_q[s-1][QUOT_W-2:0], take};
        den_q[s] <= den_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  assign res_o.quot = nq_q[DIV_STAGES-1];
  assign res_o.ovf  = ovf_q[DIV_STAGES-1];
  assign res_o.neg  = neg_q[DIV_STAGES-1];

endmodule
